[sv/tosa_pkg.sv]
// Types and constants shared by the stillness alarm modules.
`default_nettype none
package tosa_pkg;
	localparam int ID_W        = 16;
	localparam int CLS_W       = 8;
	localparam int BOX_W       = 12;
	localparam int CNT_W       = 16;
	localparam int MTH_W       = 14;
	localparam int SLOT_MAX_W  = 6;
	localparam int CRD_MAX_W   = 18;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 40;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_THR = 1'b1;

	localparam logic [CLS_W-1:0] UNDERWATER_CLASS = 8'd1;
	localparam logic [15:0]      UNFILLED_DIST    = 16'd200;
	localparam logic [CNT_W-1:0] COUNT_MAX        = 16'hFFFF;
	localparam logic [MTH_W-1:0] MOVE_THR_RESET   = 14'd20;
	localparam logic [CNT_W-1:0] TIME_THR_RESET   = 16'd30;

	// one classified item on its way from the front to the back
	typedef struct packed {
		logic                  frame_end;
		logic                  miss;
		logic                  fresh;
		logic [SLOT_MAX_W-1:0] slot;
		logic [ID_W-1:0]       id;
		logic [CLS_W-1:0]      cls;
		logic [CRD_MAX_W-1:0]  cx;
		logic [CRD_MAX_W-1:0]  cy;
	} cmd_t;

	typedef struct packed {
		logic             kind;
		logic [ID_W-1:0]  id;
		logic             drowning;
		logic [CNT_W-1:0] still;
		logic             table_full;
		logic             frame_alarm;
	} res_t;
endpackage
`default_nettype wire

[sv/tosa_front.sv]
// Track table lookup, allocation and frame-end eviction.
`default_nettype none
module tosa_front #(
	parameter int MAX_TRACKS = 16,
	parameter int COORD_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          acc,
	input  wire logic                          mode,
	input  wire logic [tosa_pkg::IN_DATA_W-1:0] data,
	output tosa_pkg::cmd_t                     cmd
);
	import tosa_pkg::*;

	localparam int SW = $clog2(MAX_TRACKS);
	localparam int CW = COORD_BITS + 2;

	logic [MAX_TRACKS-1:0] valid_q;
	logic [MAX_TRACKS-1:0] seen_q;
	logic [ID_W-1:0]       tag_q [MAX_TRACKS];

	logic [ID_W-1:0]  id;
	logic [15:0]      bx16, by16, bw16, bh16;
	logic [CW-1:0]    cx, cy;
	logic             hit_any, free_any;
	logic [SW-1:0]    hit_idx, free_idx, slot;

	assign id   = data[15:0];
	assign bx16 = 16'(data[35:24]);
	assign by16 = 16'(data[47:36]);
	assign bw16 = 16'(data[59:48]);
	assign bh16 = 16'(data[71:60]);
	assign cx = CW'({bx16[COORD_BITS-1:0], 1'b0}) + CW'(bw16[COORD_BITS-1:0]);
	assign cy = CW'({by16[COORD_BITS-1:0], 1'b0}) + CW'(bh16[COORD_BITS-1:0]);

	// lowest matching and lowest free entry
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int k = MAX_TRACKS - 1; k >= 0; k--) begin
			if (valid_q[k] && tag_q[k] == id) begin
				hit_any = 1'b1;
				hit_idx = SW'(k);
			end
			if (!valid_q[k]) begin
				free_any = 1'b1;
				free_idx = SW'(k);
			end
		end
	end

	assign slot = hit_any ? hit_idx : free_idx;

	always_comb begin
		cmd.frame_end = mode;
		cmd.miss      = !hit_any && !free_any;
		cmd.fresh     = !hit_any;
		cmd.slot      = SLOT_MAX_W'(slot);
		cmd.id        = id;
		cmd.cls       = data[23:16];
		cmd.cx        = CRD_MAX_W'(cx);
		cmd.cy        = CRD_MAX_W'(cy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seen_q  <= '0;
		end else if (acc) begin
			if (mode) begin
				// evict tracks not seen since the last frame end
				valid_q <= valid_q & seen_q;
				seen_q  <= '0;
			end else if (hit_any || free_any) begin
				valid_q[slot] <= 1'b1;
				seen_q[slot]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !mode && !hit_any && free_any) begin
			tag_q[free_idx] <= id;
		end
	end
endmodule
`default_nettype wire

[sv/tosa_queue.sv]
// Short queue of classified items between front and back.
`default_nettype none
module tosa_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tosa_pkg::cmd_t  din,
	output logic                 full,
	input  wire logic            pop,
	output tosa_pkg::cmd_t       dout,
	output logic                 empty
);
	import tosa_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	cmd_t            mem_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;

	assign full  = cnt_q == (PW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
endmodule
`default_nettype wire

[sv/tosa_back.sv]
// Centre history, distance test, still counters and result register.
`default_nettype none
module tosa_back #(
	parameter int MAX_TRACKS  = 16,
	parameter int HISTORY_LEN = 30,
	parameter int COORD_BITS  = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [tosa_pkg::MTH_W-1:0] move_thr,
	input  wire logic [tosa_pkg::CNT_W-1:0] time_thr,
	input  wire logic                      q_empty,
	input  wire tosa_pkg::cmd_t            q_cmd,
	output logic                           pop,
	input  wire logic                      out_ready,
	output logic                           out_valid,
	output tosa_pkg::res_t                 res
);
	import tosa_pkg::*;

	localparam int SW   = $clog2(MAX_TRACKS);
	localparam int HW   = $clog2(HISTORY_LEN);
	localparam int FW   = $clog2(HISTORY_LEN + 1);
	localparam int AW   = $clog2(MAX_TRACKS * HISTORY_LEN);
	localparam int CW   = COORD_BITS + 2;
	localparam int CMPW = (2 * CW + 1 > 2 * MTH_W) ? 2 * CW + 1 : 2 * MTH_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_SQ   = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [HW-1:0]     head_q [MAX_TRACKS];
	logic [FW-1:0]     fill_q [MAX_TRACKS];
	logic [CNT_W-1:0]  ctr_q  [MAX_TRACKS];
	logic              alarm_q;
	logic [2*CW-1:0]   mem [MAX_TRACKS * HISTORY_LEN];
	logic [2*CW-1:0]   rd_q;
	logic              full_s1;
	logic [CW-1:0]     dx_s2, dy_s2;
	logic [2*CW-1:0]   dx2_s3, dy2_s3;
	logic [2*MTH_W-1:0] thr2_s3;

	logic [SW-1:0]     sl_in, sl_c;
	logic [HW-1:0]     h, nh;
	logic [FW-1:0]     f, fn;
	logic [AW-1:0]     base, wa, ra;
	logic              wr_en;
	logic [CW-1:0]     cx_c, cy_c, ox, oy;
	logic [CMPW-1:0]   dsq, thr;
	logic              still;
	logic [CNT_W-1:0]  oldc, newc;
	logic              drown, ld;

	assign pop   = state_q == ST_IDLE && !q_empty;
	assign sl_in = q_cmd.slot[SW-1:0];
	assign h     = q_cmd.fresh ? '0 : head_q[sl_in];
	assign f     = q_cmd.fresh ? '0 : fill_q[sl_in];
	assign nh    = (h == HW'(HISTORY_LEN - 1)) ? '0 : h + 1'b1;
	assign fn    = (f == FW'(HISTORY_LEN)) ? f : f + 1'b1;
	assign base  = AW'(sl_in) * AW'(HISTORY_LEN);
	assign wa    = base + AW'(h);
	assign ra    = base + AW'(nh);
	assign wr_en = pop && !q_cmd.frame_end && !q_cmd.miss;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wa] <= {CW'(q_cmd.cy), CW'(q_cmd.cx)};
		rd_q <= mem[ra];
	end

	assign cx_c = CW'(cmd_q.cx);
	assign cy_c = CW'(cmd_q.cy);
	assign ox   = rd_q[CW-1:0];
	assign oy   = rd_q[2*CW-1:CW];
	assign sl_c = cmd_q.slot[SW-1:0];

	always_comb begin
		dsq   = full_s1 ? CMPW'(dx2_s3) + CMPW'(dy2_s3)
		                : CMPW'(UNFILLED_DIST) * CMPW'(UNFILLED_DIST);
		thr   = CMPW'(thr2_s3);
		still = cmd_q.cls == UNDERWATER_CLASS && dsq < thr;
		oldc  = cmd_q.fresh ? '0 : ctr_q[sl_c];
		newc  = still ? ((oldc == COUNT_MAX) ? oldc : oldc + 1'b1) : '0;
		drown = newc >= time_thr;
		ld    = state_q == ST_DONE && (!out_valid || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			alarm_q   <= 1'b0;
			for (int k = 0; k < MAX_TRACKS; k++) begin
				head_q[k] <= '0;
				fill_q[k] <= '0;
				ctr_q[k]  <= '0;
			end
		end else begin
			if (ld) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (wr_en) begin
							head_q[sl_in] <= nh;
							fill_q[sl_in] <= fn;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_DONE;
				ST_DONE: begin
					if (ld) begin
						state_q <= ST_IDLE;
						if (cmd_q.frame_end) begin
							alarm_q <= 1'b0;
						end else if (!cmd_q.miss) begin
							ctr_q[sl_c] <= newc;
							if (drown) alarm_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= q_cmd;
			full_s1 <= fn == FW'(HISTORY_LEN);
		end
		if (state_q == ST_READ) begin
			dx_s2 <= (cx_c > ox) ? cx_c - ox : ox - cx_c;
			dy_s2 <= (cy_c > oy) ? cy_c - oy : oy - cy_c;
		end
		if (state_q == ST_SQ) begin
			dx2_s3  <= dx_s2 * dx_s2;
			dy2_s3  <= dy_s2 * dy_s2;
			thr2_s3 <= move_thr * move_thr;
		end
		if (ld) begin
			res.kind        <= cmd_q.frame_end;
			res.id          <= cmd_q.frame_end ? '0 : cmd_q.id;
			res.drowning    <= !cmd_q.frame_end && !cmd_q.miss && drown;
			res.still       <= (cmd_q.frame_end || cmd_q.miss) ? '0 : newc;
			res.table_full  <= !cmd_q.frame_end && cmd_q.miss;
			res.frame_alarm <= cmd_q.frame_end && alarm_q;
		end
	end

	a_read_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> $past(state_q) == ST_IDLE)
		else $error("history read not preceded by dispatch");
	a_drown_sets_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		ld && !cmd_q.frame_end && !cmd_q.miss && drown |=> alarm_q)
		else $error("drowning result did not set frame alarm");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> fill_q[sl_c] <= FW'(HISTORY_LEN) && fill_q[sl_c] != '0)
		else $error("history fill out of range");
	a_full_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ld && cmd_q.miss && !cmd_q.frame_end |=> res.table_full && !res.drowning)
		else $error("dropped track result malformed");
endmodule
`default_nettype wire

[sv/tracked_object_stillness_alarm.sv]
// Each accepted item waits in the queue, then the back end handles it alone: a tracked
// detection passes through the READ, SQ and DONE states, an end of frame or dropped track goes
// straight to DONE. The back end takes no new item from the queue until the last result is
// loaded, and it waits while the output is stalled; the single history memory is used in turn.
// Reset clears the track table, fill counts, still counters and alarm at once;
// the centre history memory is not cleared and is only read after being written.
`default_nettype none
module tracked_object_stillness_alarm #(
	parameter int MAX_TRACKS  = 16,
	parameter int HISTORY_LEN = 30,
	parameter int COORD_BITS  = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// track id, class, box x, box y, box width, box height
	input  wire logic [tosa_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// track id, drowning, still count, table full, frame alarm, zero pad
	output logic [tosa_pkg::OUT_DATA_W-1:0]      m_tdata,
	// result kind
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tosa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tosa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tosa_pkg::*;

	logic [MTH_W-1:0] move_thr_q;
	logic [CNT_W-1:0] time_thr_q;
	cmd_t             f_cmd, q_cmd;
	logic             q_full, q_empty, pop, acc;
	res_t             res;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign acc       = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_thr_q <= MOVE_THR_RESET;
			time_thr_q <= TIME_THR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MOVE_THR: move_thr_q <= cfg_data[MTH_W-1:0];
				REG_TIME_THR: time_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tosa_front #(.MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .acc(acc), .mode(s_tuser), .data(s_tdata),
		.cmd(f_cmd)
	);

	tosa_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(acc), .din(f_cmd), .full(q_full),
		.pop(pop), .dout(q_cmd), .empty(q_empty)
	);

	tosa_back #(
		.MAX_TRACKS(MAX_TRACKS), .HISTORY_LEN(HISTORY_LEN), .COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .move_thr(move_thr_q), .time_thr(time_thr_q),
		.q_empty(q_empty), .q_cmd(q_cmd), .pop(pop), .out_ready(m_tready),
		.out_valid(m_tvalid), .res(res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {5'b0, res.frame_alarm, res.table_full, res.still, res.drowning, res.id};
endmodule
`default_nettype wire

[tb/sv/tb_tracked_object_stillness_alarm.sv]
// Testbench for the stillness alarm: directed table, random traffic, and checks against a predictor.
`default_nettype none
module tb_tracked_object_stillness_alarm;
	timeunit 1ns;
	timeprecision 1ps;
	import tosa_pkg::*;

	localparam int NTRK      = 16;
	localparam int HLEN      = 30;
	localparam int EXP_DEPTH = 4096;
	localparam int MAX_ROWS  = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tracked_object_stillness_alarm dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	typedef struct {
		logic             frame_end;
		logic [ID_W-1:0]  id;
		logic [CLS_W-1:0] cls;
		logic [BOX_W-1:0] bx, by, bw, bh;
	} det_t;

	typedef struct {
		det_t d;
		logic has_exp;
		res_t r;
	} row_t;

	// predictor state
	logic [MTH_W-1:0] move_thr;
	logic [CNT_W-1:0] time_thr;
	logic [ID_W-1:0]  tag [NTRK];
	logic             live [NTRK];
	logic             seen [NTRK];
	logic [17:0]      hist_x [NTRK][HLEN];
	logic [17:0]      hist_y [NTRK][HLEN];
	int               head [NTRK];
	int               fill [NTRK];
	logic [CNT_W-1:0] still [NTRK];
	logic             frame_alarm_acc;

	// expected results in order, written by the sender, read by the checker
	res_t exp_mem [EXP_DEPTH];
	int   exp_wr = 0;
	int   exp_rd = 0;
	row_t rows [MAX_ROWS];
	int   nrows = 0;
	int   mismatches = 0;
	int   pred_err = 0;
	int   send_idle_pct = 0, recv_idle_pct = 0;
	int   hold_req = 0;
	int   hold_ack = 0;
	int   hold_left = 0;

	function automatic res_t predict_alarm(det_t d);
		res_t r;
		int k, h;
		logic [17:0] cx, cy;
		longint dx, dy, dist2, thr2;
		r = '0;
		if (d.frame_end) begin
			for (k = 0; k < NTRK; k++) begin
				if (live[k] && !seen[k]) live[k] = 1'b0;
				seen[k] = 1'b0;
			end
			r.kind = 1'b1;
			r.frame_alarm = frame_alarm_acc;
			frame_alarm_acc = 1'b0;
			return r;
		end
		r.id = d.id;
		k = -1;
		for (int i = 0; i < NTRK; i++)
			if (k < 0 && live[i] && tag[i] == d.id) k = i;
		if (k < 0) begin
			for (int i = 0; i < NTRK; i++)
				if (k < 0 && !live[i]) begin
					k = i; live[i] = 1'b1; tag[i] = d.id;
					head[i] = 0; fill[i] = 0; still[i] = '0; seen[i] = 1'b0;
				end
		end
		if (k < 0) begin
			r.table_full = 1'b1;
			return r;
		end
		seen[k] = 1'b1;
		cx = 18'(2 * d.bx + d.bw);
		cy = 18'(2 * d.by + d.bh);
		h = head[k];
		hist_x[k][h] = cx;
		hist_y[k][h] = cy;
		h = (h + 1) % HLEN;
		head[k] = h;
		if (fill[k] < HLEN) fill[k]++;
		if (fill[k] >= HLEN) begin
			dx = longint'(cx) - longint'(hist_x[k][h]);
			dy = longint'(cy) - longint'(hist_y[k][h]);
			dist2 = dx * dx + dy * dy;
		end else begin
			dist2 = 200 * 200;
		end
		thr2 = longint'(move_thr) * longint'(move_thr);
		if (d.cls == UNDERWATER_CLASS && dist2 < thr2) begin
			if (still[k] != COUNT_MAX) still[k]++;
		end else begin
			still[k] = '0;
		end
		r.drowning = still[k] >= time_thr;
		if (r.drowning) frame_alarm_acc = 1'b1;
		r.still = still[k];
		return r;
	endfunction

	// receiver with random stalls and an optional long hold-off
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= 300;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.id = m_tdata[15:0];
			got.drowning = m_tdata[16];
			got.still = m_tdata[32:17];
			got.table_full = m_tdata[33];
			got.frame_alarm = m_tdata[34];
			if (exp_rd == exp_wr) begin
				mismatches++;
				if (mismatches + pred_err <= 10)
					$display("unexpected result kind=%0d id=%0d", got.kind, got.id);
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got !== want || m_tdata[39:35] !== 5'd0) begin
					mismatches++;
					if (mismatches + pred_err <= 10) begin
						$display("mismatch: exp kind=%0d id=%0d dr=%0d st=%0d tf=%0d fa=%0d",
							want.kind, want.id, want.drowning, want.still,
							want.table_full, want.frame_alarm);
						$display("          got kind=%0d id=%0d dr=%0d st=%0d tf=%0d fa=%0d",
							got.kind, got.id, got.drowning, got.still,
							got.table_full, got.frame_alarm);
					end
				end
			end
		end
	end

	// valid stays up between items unless the random sender idle drops it; drain_results drops it
	task automatic send_item(det_t d, logic has_exp = 1'b0, res_t fixed = '0);
		res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= d.frame_end;
		s_tdata <= {d.bh, d.bw, d.by, d.bx, d.cls, d.id};
		do @(posedge clk); while (!s_tready);
		r = predict_alarm(d);
		if (has_exp && r !== fixed) begin
			pred_err++;
			if (mismatches + pred_err <= 10)
				$display("predictor disagrees with table row for id %0d", d.id);
		end
		exp_mem[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MOVE_THR) move_thr = val[MTH_W-1:0];
		else time_thr = val;
		@(posedge clk);
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (exp_rd != exp_wr && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 200000) begin
			$display("FAILURE");
			$finish;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic add_row(det_t d, logic has_exp, res_t r);
		rows[nrows].d = d;
		rows[nrows].has_exp = has_exp;
		rows[nrows].r = r;
		nrows++;
	endtask

	function automatic det_t mk(bit fe, int id, int cls, int bx, int by, int bw, int bh);
		det_t d;
		d.frame_end = fe;
		d.id = ID_W'(id);
		d.cls = CLS_W'(cls);
		d.bx = BOX_W'(bx); d.by = BOX_W'(by); d.bw = BOX_W'(bw); d.bh = BOX_W'(bh);
		return d;
	endfunction

	function automatic res_t mkr(bit kind, int id, bit dr, int st, bit tf, bit fa);
		res_t r;
		r.kind = kind; r.id = ID_W'(id); r.drowning = dr; r.still = CNT_W'(st);
		r.table_full = tf; r.frame_alarm = fa;
		return r;
	endfunction

	// random detection biased towards a small pool of still objects
	function automatic det_t rand_det(int pool);
		det_t d;
		d.frame_end = 1'b0;
		d.id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(65535))
		                               : ID_W'($urandom_range(pool - 1));
		d.cls = ($urandom_range(9) < 8) ? UNDERWATER_CLASS : CLS_W'($urandom_range(255));
		if ($urandom_range(9) < 7) begin
			d.bx = BOX_W'(100 + d.id[2:0] + $urandom_range(2));
			d.by = BOX_W'(200 + $urandom_range(2));
			d.bw = BOX_W'(40 + $urandom_range(3));
			d.bh = BOX_W'(30 + $urandom_range(3));
		end else begin
			d.bx = BOX_W'($urandom_range(4095)); d.by = BOX_W'($urandom_range(4095));
			d.bw = BOX_W'($urandom_range(4095)); d.bh = BOX_W'($urandom_range(4095));
		end
		return d;
	endfunction

	initial begin
		move_thr = MOVE_THR_RESET;
		time_thr = TIME_THR_RESET;
		frame_alarm_acc = 1'b0;
		for (int i = 0; i < NTRK; i++) begin
			live[i] = 1'b0; seen[i] = 1'b0; head[i] = 0; fill[i] = 0; still[i] = '0;
			tag[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		add_row(mk(1'b1, 0, 0, 0, 0, 0, 0), 1'b1, mkr(1'b1, 0, 1'b0, 0, 1'b0, 1'b0));
		add_row(mk(1'b0, 16'hFFFF, 8'hFF, 4095, 4095, 4095, 4095), 1'b1,
			mkr(1'b0, 16'hFFFF, 1'b0, 0, 1'b0, 1'b0));
		add_row(mk(1'b0, 0, 1, 0, 0, 0, 0), 1'b1, mkr(1'b0, 0, 1'b0, 0, 1'b0, 1'b0));
		add_row(mk(1'b0, 0, 1, 0, 0, 0, 0), 1'b0, '0);
		add_row(mk(1'b0, 16'h5555, 8'hAA, 12'hAAA, 12'h555, 12'hAAA, 12'h555), 1'b0, '0);
		for (int i = 0; i < 13; i++) add_row(mk(1'b0, 100 + i, 1, i, i, 1, 1), 1'b0, '0);
		add_row(mk(1'b0, 999, 1, 5, 5, 5, 5), 1'b1, mkr(1'b0, 999, 1'b0, 0, 1'b1, 1'b0));
		add_row(mk(1'b1, 0, 0, 0, 0, 0, 0), 1'b1, mkr(1'b1, 0, 1'b0, 0, 1'b0, 1'b0));
		add_row(mk(1'b1, 0, 0, 0, 0, 0, 0), 1'b1, mkr(1'b1, 0, 1'b0, 0, 1'b0, 1'b0));
		for (int i = 0; i < nrows; i++) send_item(rows[i].d, rows[i].has_exp, rows[i].r);
		drain_results();

		// zero time threshold, huge move threshold: everything drowns
		write_reg(REG_TIME_THR, 16'd0);
		write_reg(REG_MOVE_THR, 16'h3FFF);
		for (int i = 0; i < 40; i++) send_item(mk(1'b0, 7, 1, 1, 1, 1, 1));
		send_item(mk(1'b1, 0, 0, 0, 0, 0, 0));
		drain_results();
		write_reg(REG_MOVE_THR, 16'd0);
		write_reg(REG_TIME_THR, 16'hFFFF);
		for (int i = 0; i < 35; i++) send_item(mk(1'b0, 7, 1, 1, 1, 1, 1));
		drain_results();

		// long receiver hold-off while the sender keeps offering
		write_reg(REG_MOVE_THR, 16'd20);
		write_reg(REG_TIME_THR, 16'd5);
		hold_req++;
		for (int i = 0; i < 40; i++) send_item(rand_det(6));
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 56 : 0;
			recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 6 : 0;
			drain_results();
			write_reg(REG_MOVE_THR, CFG_DATA_W'($urandom_range(40, 6)));
			write_reg(REG_TIME_THR, CFG_DATA_W'($urandom_range(40, 0)));
			for (int i = 0; i < 470; i++) begin
				if ($urandom_range(7) == 0) send_item(mk(1'b1, $urandom_range(65535),
					$urandom_range(255), $urandom_range(4095), $urandom_range(4095),
					$urandom_range(4095), $urandom_range(4095)));
				else send_item(rand_det(20));
			end
		end

		drain_results();
		if (mismatches == 0 && pred_err == 0 && exp_rd == exp_wr) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire
